// File: design/thtsk_pkg.sv
// Package for the tilt-head twin-spindle kinematics block.
// Holds payload structs, register indexes, CORDIC constants and the angle table.
// No dependencies.
`default_nettype none
package thtsk_pkg;

  localparam int CORDIC_STAGES = 24;
  // Delay through the angle front end, the CORDIC stages and the sign fix.
  localparam int SC_LAT = CORDIC_STAGES + 5;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_PIVOT_LENGTH     = 2'd0,
    REG_TOOL_LENGTH      = 2'd1,
    REG_SPINDLE_DISTANCE = 2'd2,
    REG_NONE             = 2'd3
  } thtsk_reg_t;

  typedef struct packed {
    logic               command;
    logic               spindle_select;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] tilt_angle;
    logic signed [31:0] rotary_angle;
  } thtsk_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               overflow;
  } thtsk_out_t;

  // atan(2^-i) with 2^32 units per turn.
  function automatic logic [31:0] atan_lut(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'd536870912;   1: v = 32'd316933406;  2: v = 32'd167458907;
      3: v = 32'd85004756;    4: v = 32'd42667331;   5: v = 32'd21354465;
      6: v = 32'd10679838;    7: v = 32'd5340245;    8: v = 32'd2670163;
      9: v = 32'd1335087;     10: v = 32'd667544;    11: v = 32'd333772;
      12: v = 32'd166886;     13: v = 32'd83443;     14: v = 32'd41722;
      15: v = 32'd20861;      16: v = 32'd10430;     17: v = 32'd5215;
      18: v = 32'd2608;       19: v = 32'd1304;      20: v = 32'd652;
      21: v = 32'd326;        22: v = 32'd163;       23: v = 32'd81;
      24: v = 32'd41;         25: v = 32'd20;        26: v = 32'd10;
      27: v = 32'd5;          28: v = 32'd3;         29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/thtsk_sincos.sv
// Pipelined sine and cosine of a 32-bit angle in 1/65536 degree units, Q30 results.
// Angle reduction to a binary angle, quadrant fold, then the pipelined CORDIC stages.
// Depends on thtsk_pkg.
`default_nettype none
module thtsk_sincos (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] angle,
  output logic signed [31:0]      sin_q,
  output logic signed [31:0]      cos_q
);
  import thtsk_pkg::*;

  // Reciprocal of 45 scaled by 2^36; exact for numerators below 2^30.
  localparam logic [60:0] RECIP45 = 61'd1527099484;
  // 2^29 = 45 * 11930464 + 32.
  localparam logic [31:0] TURN_PART = 32'd11930464;

  logic [16:0] u_r;
  logic [15:0] al1_r;
  logic [7:0]  q0_r;
  logic [8:0]  rem_r;
  logic [15:0] al2_r;
  logic [24:0] qq_r;
  logic [31:0] remmul_r;

  logic signed [33:0] cx_r [0:CORDIC_STAGES];
  logic signed [33:0] cy_r [0:CORDIC_STAGES];
  logic signed [33:0] cz_r [0:CORDIC_STAGES];
  logic               cneg_r [0:CORDIC_STAGES];

  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;

  logic [16:0] u_nxt;
  logic [30:0] q0_prod;
  logic [16:0] diff;
  logic [9:0]  rem_nxt;
  logic [29:0] n2;
  logic [60:0] n2_prod;
  logic [31:0] zb;
  logic signed [33:0] zs;
  logic signed [33:0] zf_nxt;
  logic               neg_nxt;

  // Upper half of the angle reduced modulo 360: the offset keeps it positive.
  assign u_nxt   = {1'b0, ~angle[31], angle[30:16]} + 17'd352;
  assign q0_prod = 31'(u_nxt) * 31'd11650;

  always_comb begin
    diff    = u_r - 17'(q0_r) * 17'd360;
    rem_nxt = diff[9:0];
    if (rem_nxt >= 10'd360) begin
      rem_nxt = rem_nxt - 10'd360;
    end
  end

  assign n2      = 30'({rem_r, 5'b0}) + 30'({al2_r, 13'b0}) + 30'd22;
  assign n2_prod = 61'(n2) * RECIP45;

  always_comb begin
    zb      = remmul_r + 32'(qq_r);
    zs      = 34'(signed'(zb));
    zf_nxt  = zs;
    neg_nxt = 1'b0;
    if (zs > 34'sd1073741824) begin
      zf_nxt  = zs - 34'sd2147483648;
      neg_nxt = 1'b1;
    end else if (zs < -34'sd1073741824) begin
      zf_nxt  = zs + 34'sd2147483648;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r      <= u_nxt;
      al1_r    <= angle[15:0];
      q0_r     <= q0_prod[29:22];
      rem_r    <= rem_nxt[8:0];
      al2_r    <= al1_r;
      qq_r     <= n2_prod[60:36];
      remmul_r <= 32'(rem_r) * TURN_PART;
      cx_r[0]   <= CORDIC_X0;
      cy_r[0]   <= '0;
      cz_r[0]   <= zf_nxt;
      cneg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [33:0] ATAN_I = 34'(signed'({1'b0, atan_lut(i)}));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][33]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ATAN_I;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ATAN_I;
        end
        cneg_r[i+1] <= cneg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= cneg_r[CORDIC_STAGES] ? 32'(-cy_r[CORDIC_STAGES]) : 32'(cy_r[CORDIC_STAGES]);
      cos_r <= cneg_r[CORDIC_STAGES] ? 32'(-cx_r[CORDIC_STAGES]) : 32'(cx_r[CORDIC_STAGES]);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
`default_nettype wire

// File: design/tilt_head_twin_spindle_kinematics.sv
// Top level of the tilt-head twin-spindle forward and inverse kinematics pipeline.
// Instantiates two thtsk_sincos units; depends on thtsk_pkg.
`default_nettype none
//
//  Channel | Ports                                   | Transaction
//  --------+-----------------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data             | one pose or joint conversion
//  result  | out_valid, out_ready, out_data          | one saturated X Y Z plus flag
//  config  | cfg_we, cfg_index, cfg_wdata            | one register write, no wait
//
// One transaction is accepted every cycle while the pipeline advances. Each
// transaction passes through angle reduction, the CORDIC stages, a sign fix and
// then the products, sums and saturation. The whole pipeline advances together;
// it holds only when the output register is full and out_ready is low. Reset clears
// the valid bits and loads the register reset values; data registers are not reset.
module tilt_head_twin_spindle_kinematics (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire thtsk_pkg::thtsk_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output thtsk_pkg::thtsk_out_t   out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_wdata
);
  import thtsk_pkg::*;

  // Position times Q30 factor, rounded to nearest with ties up.
  function automatic logic signed [39:0] mulq(input logic signed [33:0] v,
                                              input logic signed [31:0] f);
    logic signed [65:0] p;
    p = v * f;
    p = p + 66'sd536870912;
    return 40'(p >>> 30);
  endfunction

  function automatic logic [32:0] sat32(input logic signed [39:0] v);
    logic [32:0] r;
    if (v > 40'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -40'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [29:0]        pivot_r;
  logic signed [30:0] tool_r;
  logic [29:0]        dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= 30'd153600;
      tool_r  <= '0;
      dist_r  <= 30'd512000;
    end else if (cfg_we) begin
      unique case (thtsk_reg_t'(cfg_index))
        REG_PIVOT_LENGTH:     pivot_r <= cfg_wdata[29:0];
        REG_TOOL_LENGTH:      tool_r  <= signed'(cfg_wdata);
        REG_SPINDLE_DISTANCE: dist_r  <= cfg_wdata[29:0];
        default: ;
      endcase
    end
  end

  logic signed [39:0] p_s, t_s, d_s;
  logic signed [33:0] l_s;
  assign p_s = 40'(signed'({1'b0, pivot_r}));
  assign t_s = 40'(tool_r);
  assign d_s = 40'(signed'({1'b0, dist_r}));
  assign l_s = 34'(p_s + t_s);

  // The whole pipeline moves when the output register can take a result.
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Payload and valid travel alongside the two trig units.
  thtsk_in_t dl_r [1:SC_LAT];
  logic      vl_r [1:SC_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[1] <= in_data;
    end
  end
  for (genvar k = 2; k <= SC_LAT; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (adv) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[1] <= 1'b0;
    end else if (adv) begin
      vl_r[1] <= in_valid;
    end
  end
  for (genvar k = 2; k <= SC_LAT; k++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k] <= 1'b0;
      end else if (adv) begin
        vl_r[k] <= vl_r[k-1];
      end
    end
  end

  logic signed [31:0] sb, cb, sr, cr;

  thtsk_sincos u_tilt (
    .clk   (clk),
    .en    (adv),
    .angle (in_data.tilt_angle),
    .sin_q (sb),
    .cos_q (cb)
  );

  thtsk_sincos u_rotary (
    .clk   (clk),
    .en    (adv),
    .angle (in_data.rotary_angle),
    .sin_q (sr),
    .cos_q (cr)
  );

  thtsk_in_t tr;
  assign tr = dl_r[SC_LAT];

  // Stage 1: pivot offset products; inverse removes the tool length from Z.
  logic               m1_v_r;
  logic               m1_inv_r, m1_sub_r;
  logic signed [39:0] m1_x_r, m1_y_r, m1_z_r;
  logic signed [39:0] m1_ls_r, m1_lc_r;
  logic signed [31:0] m1_sr_r, m1_cr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_inv_r <= tr.command;
      m1_sub_r <= tr.spindle_select;
      m1_x_r   <= 40'(tr.in_x);
      m1_y_r   <= 40'(tr.in_y);
      m1_z_r   <= tr.command ? 40'(tr.in_z) - t_s : 40'(tr.in_z);
      m1_ls_r  <= mulq(l_s, sb);
      m1_lc_r  <= mulq(l_s, cb);
      m1_sr_r  <= sr;
      m1_cr_r  <= cr;
    end
  end

  // Stage 2: forward builds the head-offset point and mirrors it for the sub spindle.
  logic               m2_v_r;
  logic               m2_inv_r, m2_sub_r;
  logic signed [33:0] m2_a_r, m2_b_r;
  logic signed [39:0] m2_z_r, m2_ls_r, m2_lc_r;
  logic signed [31:0] m2_sr_r, m2_cr_r;
  logic signed [39:0] qx_f, qy_f, qz_f;

  always_comb begin
    qx_f = m1_x_r - m1_ls_r;
    qy_f = m1_y_r;
    qz_f = m1_z_r + p_s - m1_lc_r;
    if (m1_sub_r) begin
      qy_f = -qy_f;
      qz_f = d_s - qz_f;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_inv_r <= m1_inv_r;
      m2_sub_r <= m1_sub_r;
      m2_a_r   <= m1_inv_r ? 34'(m1_x_r) : 34'(qx_f);
      m2_b_r   <= m1_inv_r ? 34'(m1_y_r) : 34'(qy_f);
      m2_z_r   <= m1_inv_r ? m1_z_r : qz_f;
      m2_ls_r  <= m1_ls_r;
      m2_lc_r  <= m1_lc_r;
      m2_sr_r  <= m1_sr_r;
      m2_cr_r  <= m1_cr_r;
    end
  end

  // Stage 3: the four rotary products, shared by both directions.
  logic               m3_v_r;
  logic               m3_inv_r, m3_sub_r;
  logic signed [39:0] m3_ac_r, m3_bs_r, m3_bc_r, m3_as_r;
  logic signed [39:0] m3_z_r, m3_ls_r, m3_lc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_inv_r <= m2_inv_r;
      m3_sub_r <= m2_sub_r;
      m3_ac_r  <= mulq(m2_a_r, m2_cr_r);
      m3_bs_r  <= mulq(m2_b_r, m2_sr_r);
      m3_bc_r  <= mulq(m2_b_r, m2_cr_r);
      m3_as_r  <= mulq(m2_a_r, m2_sr_r);
      m3_z_r   <= m2_z_r;
      m3_ls_r  <= m2_ls_r;
      m3_lc_r  <= m2_lc_r;
    end
  end

  // Stage 4: final sums for either direction.
  logic               m4_v_r;
  logic signed [39:0] m4_x_r, m4_y_r, m4_z_r;
  logic signed [39:0] rx_c, ry_c, rz_c, iqy, iqz;

  always_comb begin
    iqy = m3_bc_r - m3_as_r;
    iqz = m3_z_r;
    if (m3_sub_r) begin
      iqy = -iqy;
      iqz = d_s - iqz;
    end
    if (m3_inv_r) begin
      rx_c = m3_ac_r + m3_bs_r + m3_ls_r;
      ry_c = iqy;
      rz_c = iqz - p_s + m3_lc_r;
    end else begin
      rx_c = m3_ac_r - m3_bs_r;
      ry_c = m3_as_r + m3_bc_r;
      rz_c = m3_z_r + t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_x_r <= rx_c;
      m4_y_r <= ry_c;
      m4_z_r <= rz_c;
    end
  end

  // Stage 5: saturation into the output register.
  logic [32:0] sx_c, sy_c, sz_c;
  thtsk_out_t  out_r;

  assign sx_c = sat32(m4_x_r);
  assign sy_c = sat32(m4_y_r);
  assign sz_c = sat32(m4_z_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_x    <= signed'(sx_c[31:0]);
      out_r.out_y    <= signed'(sy_c[31:0]);
      out_r.out_z    <= signed'(sz_c[31:0]);
      out_r.overflow <= sx_c[32] | sy_c[32] | sz_c[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      m4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1_v_r      <= vl_r[SC_LAT];
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      m4_v_r      <= m3_v_r;
      out_valid_r <= m4_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
